// ===== rtl/core/ppe_pkg.sv =====
// Package: shared types, constants and arithmetic helpers of the particle pool engine
package ppe_pkg;

    localparam int unsigned DefPoolSlots = 64;
    localparam logic [31:0] MinLife      = 32'd3277;

    typedef enum logic [1:0] {
        MODE_EMIT   = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_RENDER = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_START_COLOUR = 3'd0,
        CFG_END_COLOUR   = 3'd1,
        CFG_START_SIZE   = 3'd2,
        CFG_END_SIZE     = 3'd3,
        CFG_GRAVITY      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] life_span;
        logic [31:0] time_step;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_colour;
        logic [15:0] out_size;
        logic        empty_res;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    // Saturate a 34-bit signed sum to 32 bits
    function automatic logic [31:0] sat34(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q16.16 product (already registered) shifted down by 16, floor, saturated
    function automatic logic [31:0] shr16_sat(input logic signed [64:0] p);
        logic signed [48:0] s;
        logic [31:0] r;
        s = p[64:16];
        if (s > 49'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (s < -49'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = s[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/ppe_if.sv =====
// Interfaces: valid/ready channels for input items, result items and register writes
interface ppe_in_if;
    logic                valid;
    logic                ready;
    ppe_pkg::in_item_t   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppe_out_if;
    logic                valid;
    logic                ready;
    ppe_pkg::out_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppe_cfg_if;
    logic                valid;
    logic                ready;
    ppe_pkg::cfg_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ppe_div.sv =====
// Module: restoring divider giving floor((age << 16) / lifetime) clamped to 16 bits
module ppe_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] age,
    input  logic [31:0] life,
    output logic        done,
    output logic [15:0] quo
);
    import ppe_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [47:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [47:0] q_reg, q_next;
    logic [32:0] trial;
    logic [32:0] rem_sh;

    assign rem_sh = {rem_reg[31:0], num_reg[47]};
    assign trial  = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        done      = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            num_next  = {age, 16'd0};
            rem_next  = '0;
            den_next  = (life == 32'd0) ? 32'd1 : life;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[46:0], 1'b0};
            if (!trial[32])
            begin
                rem_next = trial;
                q_next   = {q_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
                busy_next = 1'b0;
        end
        else if (cnt_reg == 6'd48)
        begin
            done     = 1'b1;
            cnt_next = 6'd0;
        end
    end

    assign quo = (q_reg[47:16] != 32'd0) ? 16'hFFFF : q_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

endmodule

// ===== rtl/core/particle_pool_engine.sv =====
// Top level: particle pool engine with memory-held slot state and a slot-walking sequencer
// Emit: probes slots from the cursor (1 to POOL_SLOTS), then writes the chosen slot.
// Tick: skips inactive slots, retires expired ones, else updates position and velocity.
// Render: runs the 48-step divider for each active slot and skips inactive slots,
// holding on output stalls; an item ends in idle, where the next one is taken.
// Reset clears alive bits, cursor, control and config registers; slot memory not cleared.
module particle_pool_engine #(
    parameter int unsigned POOL_SLOTS = ppe_pkg::DefPoolSlots
) (
    input  logic  clk,
    input  logic  rst_n,
    ppe_in_if.sink    in_ch,
    ppe_out_if.source out_ch,
    ppe_cfg_if.sink   cfg_ch
);
    import ppe_pkg::*;

    localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam logic [SW:0] LastSlot = (SW+1)'(POOL_SLOTS - 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SCAN  = 10'b0000000010,
        ST_EMIT  = 10'b0000000100,
        ST_RD    = 10'b0000001000,
        ST_T1    = 10'b0000010000,
        ST_T2    = 10'b0000100000,
        ST_T3    = 10'b0001000000,
        ST_R1    = 10'b0010000000,
        ST_R2    = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Slot memory: position, velocity, age/lifetime, appearance, gravity in one word
    logic [383:0] slot_mem [POOL_SLOTS];
    logic [383:0] slot_rd;
    logic [95:0]  pos_rd;
    logic [95:0]  vel_rd;
    logic [63:0]  al_rd;    // age, lifetime
    logic [95:0]  app_rd;   // colour s, colour e, size s, size e
    logic [31:0]  grv_rd;

    logic [POOL_SLOTS-1:0] alive_reg, alive_next;
    logic [SW-1:0] cursor_reg, cursor_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW:0]   cnt_reg, cnt_next;
    logic          found_reg, found_next;
    in_item_t      item_reg;
    logic [31:0]   scol_reg, ecol_reg, grav_reg;
    logic [15:0]   ssz_reg, esz_reg;

    logic          ov_reg, ov_next;
    out_item_t     od_reg, od_next;

    logic          mem_wr;
    logic [SW-1:0] rd_addr;
    logic [95:0]   pos_w, vel_w;
    logic [63:0]   al_w;
    logic [95:0]   app_w;
    logic [31:0]   grv_w;

    // Tick datapath registers
    logic [31:0]        age_n_reg;
    logic signed [64:0] pg_reg;
    logic [31:0]        vy_reg;
    logic signed [64:0] px_reg, py_reg, pz_reg;
    logic [31:0]        nx_reg, ny_reg, nz_reg;
    logic [31:0]        shr_g;

    // Render datapath
    logic        div_start, div_done;
    logic [15:0] t_q, t_reg;
    logic [31:0] col_reg;
    logic [15:0] sz_reg;
    logic [15:0] lb3, lb2, lb1, lb0, lsz;

    logic [32:0] age_sum;
    logic [31:0] age_sat;
    logic [31:0] dt;

    logic in_take;
    logic [31:0] life_cl;

    function automatic logic [31:0] pos_add(input logic [31:0] p, input logic signed [64:0] m);
        logic [31:0] d;
        d = shr16_sat(m);
        return sat34($signed({{2{p[31]}}, p}) + $signed({{2{d[31]}}, d}));
    endfunction

    // Render interpolation
    function automatic logic [15:0] lerp(input logic [15:0] s, input logic [15:0] e,
                                         input logic [15:0] t);
        logic signed [16:0] d;
        logic signed [33:0] p;
        logic signed [17:0] r;
        d = $signed({1'b0, e}) - $signed({1'b0, s});
        p = d * $signed({1'b0, t});
        r = $signed({2'b00, s}) + $signed(p[33:16]);
        return r[15:0];
    endfunction

    ppe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .age   (al_rd[63:32]),
        .life  (al_rd[31:0]),
        .done  (div_done),
        .quo   (t_q)
    );

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_take      = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    assign dt      = item_reg.time_step;
    assign age_sum = {1'b0, al_rd[63:32]} + {1'b0, dt};
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign life_cl = (item_reg.life_span < MinLife) ? MinLife : item_reg.life_span;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg <= 32'hFFFF_FFFF;
            ecol_reg <= 32'd0;
            ssz_reg  <= 16'd256;
            esz_reg  <= 16'd0;
            grav_reg <= 32'd0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.index)
                CFG_START_COLOUR: scol_reg <= cfg_ch.data.data;
                CFG_END_COLOUR:   ecol_reg <= cfg_ch.data.data;
                CFG_START_SIZE:   ssz_reg  <= cfg_ch.data.data[15:0];
                CFG_END_SIZE:     esz_reg  <= cfg_ch.data.data[15:0];
                CFG_GRAVITY:      grav_reg <= cfg_ch.data.data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_ch.data;
    end

    // Memory read port: registered read at the slot under work
    assign rd_addr = slot_next;
    always_ff @(posedge clk)
    begin
        slot_rd <= slot_mem[rd_addr];
    end

    assign pos_rd = slot_rd[383:288];
    assign vel_rd = slot_rd[287:192];
    assign al_rd  = slot_rd[191:128];
    assign app_rd = slot_rd[127:32];
    assign grv_rd = slot_rd[31:0];

    // Memory write port: whole word, unchanged fields taken from the read data
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            slot_mem[slot_reg] <= {pos_w, vel_w, al_w, app_w, grv_w};
    end

    assign shr_g = shr16_sat(pg_reg);

    // Tick arithmetic pipeline
    always_ff @(posedge clk)
    begin
        age_n_reg <= age_sat;
        pg_reg    <= $signed(grv_rd) * $signed({1'b0, dt});
        vy_reg    <= sat34($signed({{2{vel_rd[63]}}, vel_rd[63:32]})
                     + $signed({{2{shr_g[31]}}, shr_g}));
        px_reg    <= $signed(vel_rd[95:64]) * $signed({1'b0, dt});
        py_reg    <= $signed(vy_reg) * $signed({1'b0, dt});
        pz_reg    <= $signed(vel_rd[31:0]) * $signed({1'b0, dt});
        nx_reg    <= pos_add(pos_rd[95:64], px_reg);
        ny_reg    <= pos_add(pos_rd[63:32], py_reg);
        nz_reg    <= pos_add(pos_rd[31:0], pz_reg);
    end

    assign lb3 = lerp({8'd0, app_rd[95:88]}, {8'd0, app_rd[63:56]}, t_reg);
    assign lb2 = lerp({8'd0, app_rd[87:80]}, {8'd0, app_rd[55:48]}, t_reg);
    assign lb1 = lerp({8'd0, app_rd[79:72]}, {8'd0, app_rd[47:40]}, t_reg);
    assign lb0 = lerp({8'd0, app_rd[71:64]}, {8'd0, app_rd[39:32]}, t_reg);
    assign lsz = lerp(app_rd[31:16], app_rd[15:0], t_reg);

    always_ff @(posedge clk)
    begin
        if (div_done)
            t_reg <= t_q;
        col_reg <= {lb3[7:0], lb2[7:0], lb1[7:0], lb0[7:0]};
        sz_reg  <= lsz;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        alive_next  = alive_reg;
        cursor_next = cursor_reg;
        slot_next   = slot_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        mem_wr      = 1'b0;
        pos_w       = pos_rd;
        vel_w       = vel_rd;
        al_w        = {age_n_reg, al_rd[31:0]};
        app_w       = app_rd;
        grv_w       = grv_rd;
        div_start   = 1'b0;

        if (ov_reg && out_ch.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    unique case (in_ch.data.mode)
                        MODE_EMIT:
                        begin
                            slot_next  = cursor_reg;
                            state_next = ST_SCAN;
                        end
                        MODE_TICK, MODE_RENDER:
                        begin
                            slot_next  = '0;
                            state_next = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Probe from the cursor; fall back to the cursor when the pool is full
                if (!alive_reg[slot_reg])
                    state_next = ST_EMIT;
                else if (cnt_reg == LastSlot)
                begin
                    slot_next  = cursor_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    slot_next = (slot_reg == LastSlot[SW-1:0]) ? '0 : slot_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                mem_wr   = 1'b1;
                pos_w    = {item_reg.pos_x, item_reg.pos_y, item_reg.pos_z};
                vel_w    = {item_reg.vel_x, item_reg.vel_y, item_reg.vel_z};
                al_w     = {32'd0, life_cl};
                app_w    = {scol_reg, ecol_reg, ssz_reg, esz_reg};
                grv_w    = grav_reg;
                alive_next[slot_reg] = 1'b1;
                cursor_next = (slot_reg == LastSlot[SW-1:0]) ? '0 : slot_reg + 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RD:
            begin
                // Memory data for slot_reg is valid here
                if (!alive_reg[slot_reg])
                begin
                    if (slot_reg == LastSlot[SW-1:0])
                    begin
                        if (item_reg.mode == MODE_RENDER && !found_reg)
                        begin
                            // Wait for the output register before loading the empty marker
                            if (!ov_reg || out_ch.ready)
                            begin
                                od_next    = '0;
                                od_next.empty_res = 1'b1;
                                od_next.last      = 1'b1;
                                state_next = ST_OUT;
                            end
                        end
                        else if (item_reg.mode == MODE_RENDER)
                        begin
                            od_next.last = 1'b1;
                            state_next   = ST_OUT;
                        end
                        else
                            state_next = ST_IDLE;
                    end
                    else
                        slot_next = slot_reg + 1'b1;
                end
                else if (item_reg.mode == MODE_TICK)
                    state_next = ST_T1;
                else
                begin
                    // Flush the previously held result before starting this one
                    if (found_reg)
                    begin
                        if (!ov_reg || out_ch.ready)
                        begin
                            ov_next    = 1'b1;
                            found_next = 1'b0;
                        end
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_R1;
                    end
                end
            end
            ST_T1:
            begin
                if (age_n_reg >= al_rd[31:0])
                begin
                    mem_wr = 1'b1;
                    alive_next[slot_reg] = 1'b0;
                    state_next = ST_T3;
                end
                else
                    state_next = ST_T2;
            end
            ST_T2:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3)
                begin
                    mem_wr   = 1'b1;
                    pos_w    = {nx_reg, ny_reg, nz_reg};
                    vel_w    = {vel_rd[95:64], vy_reg, vel_rd[31:0]};
                    cnt_next = '0;
                    state_next = ST_T3;
                end
            end
            ST_T3:
            begin
                if (slot_reg == LastSlot[SW-1:0])
                    state_next = ST_IDLE;
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_R1:
            begin
                if (div_done)
                    state_next = ST_R2;
            end
            ST_R2:
            begin
                if (!cnt_reg[0])
                    cnt_next = cnt_reg + 1'b1;
                else if (!ov_reg || out_ch.ready)
                begin
                    // Hold here while the output register still carries a transfer
                    cnt_next = '0;
                    od_next  = '{out_x: pos_rd[95:64], out_y: pos_rd[63:32],
                                 out_z: pos_rd[31:0], out_colour: col_reg,
                                 out_size: sz_reg, empty_res: 1'b0, last: 1'b0};
                    found_next = 1'b1;
                    if (slot_reg == LastSlot[SW-1:0])
                    begin
                        od_next.last = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_OUT:
            begin
                // Hold the final result until the output register is free
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    found_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            alive_reg  <= '0;
            cursor_reg <= '0;
            slot_reg   <= '0;
            cnt_reg    <= '0;
            found_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            alive_reg  <= alive_next;
            cursor_reg <= cursor_next;
            slot_reg   <= slot_next;
            cnt_reg    <= cnt_next;
            found_reg  <= found_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
    end

    // An output in flight must not be overwritten by a fresh result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ch.ready |=> ov_reg && $stable(od_reg))
        else $error("result changed while stalled");

    // Input is only taken in the idle state
    a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> state_reg == ST_IDLE)
        else $error("input taken while busy");

    // An emit always leaves its chosen slot active
    a_emit_alive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |=> alive_reg[$past(slot_reg)])
        else $error("emitted slot not active");

endmodule
